>>> sv/stus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stus_pkg: shared types and constants of the string-to-unsigned scanner
// Item formats, the classified byte that the front hands to the back, the
// scan phases and the number formats the scanner knows.
// ----------------------------------------------------------------------------
package stus_pkg;

    // Field widths
    localparam int VALUE_BITS  = 64;
    localparam int OFFSET_BITS = 32;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 6;
    localparam int PROD_BITS   = VALUE_BITS + BASE_BITS;

    // Number bases
    localparam int MAX_BASE = 36;
    localparam int BASE_HEX = 16;
    localparam int BASE_DEC = 10;
    localparam int BASE_OCT = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // One input byte
    typedef struct packed {
        logic                 first;
        logic [BASE_BITS-1:0] base;
        logic                 readable;
        logic [CHAR_BITS-1:0] ch;
    } t_in_item;

    // One scan result
    typedef struct packed {
        logic [VALUE_BITS-1:0]  value;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   negative;
        logic                   overflow;
        logic                   converted;
    } t_out_item;

    // Byte after classification
    typedef struct packed {
        logic                  first;
        logic [BASE_BITS-1:0]  base;
        logic                  base_bad;
        logic                  readable;
        logic                  is_space;
        logic                  is_plus;
        logic                  is_minus;
        logic                  is_zero;
        logic                  is_x;
        logic                  is_digit;
        logic [DIGIT_BITS-1:0] digit;
    } t_cls_item;

    // Scan phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_XMARK,
        PH_DIGITS
    } t_phase;

endpackage

>>> sv/string_to_uint_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_uint_scanner_top: strtoul-style integer scanner
// Classifier, byte queue and scan engine with a registered result.
// ----------------------------------------------------------------------------
// Feed the string one byte per transfer, with first set on the byte at offset
// zero (which also carries the base). The block sustains one byte per cycle
// while the engine does not pause: each byte is classified on entry, waits in
// a four-entry queue, and is then taken by the scan engine, whose base
// multiply-add with overflow check works over the 64-bit accumulator. With
// the queue empty, a byte is first written into the queue and then taken by
// the engine, which loads the result register as it takes the byte that
// ends the scan; o_out_valid comes from that register. The engine pauses
// only while a finished result waits in the output register and the next
// byte would end a scan too. No clearing pass follows reset.
module string_to_uint_scanner_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stus_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stus_pkg::t_out_item o_out_data
);

    logic                push_valid;
    logic                push_ready;
    stus_pkg::t_cls_item push_data;
    logic                q_valid;
    logic                q_ready;
    stus_pkg::t_cls_item q_data;

    // Classifier
    stus_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Byte queue
    stus_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    // Scan engine
    stus_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_data    (q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A new result only comes from a byte the engine took
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(q_valid && q_ready))
        else $error("result appeared without an engine transfer");

    // A held result is not overwritten by engine progress
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("held result changed while engine advanced");

    // Input back-pressure only with the queue holding bytes
    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |-> q_valid)
        else $error("input stalled with empty queue");

endmodule

>>> sv/stus_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stus_front: byte classifier
// Takes input bytes and tags each one (space, sign, zero, x, digit value,
// bad base) before it goes into the queue.
// ----------------------------------------------------------------------------
module stus_front (
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stus_pkg::t_in_item  i_in_data,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output stus_pkg::t_cls_item o_push_data
);

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    logic [7:0] ch;

    assign ch = i_in_data.ch;

    // Handshake goes straight to the queue
    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

    // Classification
    always_comb begin
        o_push_data          = '0;
        o_push_data.first    = i_in_data.first;
        o_push_data.base     = i_in_data.base;
        o_push_data.base_bad = (i_in_data.base == stus_pkg::BASE_BITS'(1))
                               || (i_in_data.base > stus_pkg::BASE_BITS'(stus_pkg::MAX_BASE));
        o_push_data.readable = i_in_data.readable;
        o_push_data.is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        o_push_data.is_plus  = (ch == CH_PLUS);
        o_push_data.is_minus = (ch == CH_MINUS);
        o_push_data.is_zero  = (ch == CH_0);
        o_push_data.is_x     = (ch == CH_LX) || (ch == CH_UX);
        priority if ((ch >= CH_0) && (ch <= CH_9)) begin
            o_push_data.is_digit = 1'b1;
            o_push_data.digit    = stus_pkg::DIGIT_BITS'(ch - CH_0);
        end else if ((ch >= CH_LA) && (ch <= CH_LZ)) begin
            o_push_data.is_digit = 1'b1;
            o_push_data.digit    = stus_pkg::DIGIT_BITS'(ch - CH_LA)
                                   + stus_pkg::DIGIT_BITS'(stus_pkg::BASE_DEC);
        end else if ((ch >= CH_UA) && (ch <= CH_UZ)) begin
            o_push_data.is_digit = 1'b1;
            o_push_data.digit    = stus_pkg::DIGIT_BITS'(ch - CH_UA)
                                   + stus_pkg::DIGIT_BITS'(stus_pkg::BASE_DEC);
        end else begin
            o_push_data.is_digit = 1'b0;
            o_push_data.digit    = '0;
        end
    end

endmodule

>>> sv/stus_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stus_queue: classified byte queue
// Small register FIFO between classifier and scan engine.
// ----------------------------------------------------------------------------
module stus_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  stus_pkg::t_cls_item i_push_data,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output stus_pkg::t_cls_item o_pop_data
);

    stus_pkg::t_cls_item                r_mem [stus_pkg::QUEUE_DEPTH];
    logic [stus_pkg::QPTR_BITS-1:0]     r_wr_ptr;
    logic [stus_pkg::QPTR_BITS-1:0]     r_rd_ptr;
    logic [stus_pkg::QPTR_BITS:0]       r_count;
    logic                               push;
    logic                               pop;

    assign o_push_ready = (r_count != (stus_pkg::QPTR_BITS+1)'(stus_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/stus_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stus_back: scan engine
// Runs the scan state machine on classified bytes, one per cycle unless a finishing byte
// meets a held result, with a base multiply-add and overflow check, and holds the result register.
// ----------------------------------------------------------------------------
module stus_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  stus_pkg::t_cls_item i_q_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stus_pkg::t_out_item o_out_data
);

    localparam int VB = stus_pkg::VALUE_BITS;
    localparam int OB = stus_pkg::OFFSET_BITS;
    localparam int BB = stus_pkg::BASE_BITS;
    localparam int PB = stus_pkg::PROD_BITS;

    // Scan state
    stus_pkg::t_phase    r_phase, n_phase;
    logic [BB-1:0]       r_base, n_base;
    logic [VB-1:0]       r_acc, n_acc;
    logic [OB-1:0]       r_pos, n_pos;
    logic [OB-1:0]       r_fb, n_fb;
    logic                r_sd, n_sd;
    logic                r_sm, n_sm;
    logic                r_ov, n_ov;
    logic                r_out_valid;
    stus_pkg::t_out_item r_out_data;

    // Effective state (a first byte starts from a clean scan)
    stus_pkg::t_phase    e_phase;
    logic [BB-1:0]       e_base;
    logic [VB-1:0]       e_acc;
    logic [OB-1:0]       e_pos;
    logic                e_sd;
    logic                e_sm;
    logic                e_ov;

    // Digit path
    logic [BB-1:0]       lead_base;
    logic [BB-1:0]       d_base;
    logic [OB-1:0]       d_pos;
    logic                d_bad;
    logic [PB-1:0]       prod;
    logic                d_ovf;
    logic                lead_zero;

    // Step decode
    logic                s_fin;
    logic [OB-1:0]       s_fin_end;
    logic                s_space;
    logic                s_sign;
    logic                s_lzero;
    logic                s_xmark;
    logic                s_digit;
    logic                slot_free;
    logic                go;
    stus_pkg::t_out_item res;

    assign e_phase = i_q_data.first ? stus_pkg::PH_WS : r_phase;
    assign e_base  = i_q_data.first ? i_q_data.base : r_base;
    assign e_acc   = i_q_data.first ? '0 : r_acc;
    assign e_pos   = i_q_data.first ? '0 : r_pos;
    assign e_sd    = i_q_data.first ? 1'b0 : r_sd;
    assign e_sm    = i_q_data.first ? 1'b0 : r_sm;
    assign e_ov    = i_q_data.first ? 1'b0 : r_ov;

    // Digit path: base choice, multiply-add, overflow
    always_comb begin
        lead_base = (e_base == '0) ? BB'(stus_pkg::BASE_DEC) : e_base;
        unique case (e_phase)
            stus_pkg::PH_XMARK:  d_base = BB'(stus_pkg::BASE_HEX);
            stus_pkg::PH_ZERO,
            stus_pkg::PH_DIGITS: d_base = r_base;
            default:             d_base = lead_base;
        endcase
        d_pos     = (e_phase == stus_pkg::PH_XMARK) ? (r_pos + OB'(1)) : e_pos;
        d_bad     = !i_q_data.is_digit || (i_q_data.digit >= d_base);
        prod      = (PB'(e_acc) * PB'(d_base)) + PB'(i_q_data.digit);
        d_ovf     = |prod[PB-1:VB];
        lead_zero = ((e_base == '0) || (e_base == BB'(stus_pkg::BASE_HEX)))
                    && i_q_data.is_zero;
    end

    // Step decode
    always_comb begin
        s_fin     = 1'b0;
        s_fin_end = e_pos;
        s_space   = 1'b0;
        s_sign    = 1'b0;
        s_lzero   = 1'b0;
        s_xmark   = 1'b0;
        s_digit   = 1'b0;
        if (i_q_valid) begin
            if (i_q_data.first && i_q_data.base_bad) begin
                s_fin     = 1'b1;
                s_fin_end = '0;
            end else begin
                unique case (e_phase)
                    stus_pkg::PH_WS: begin
                        priority if (!i_q_data.readable) s_fin   = 1'b1;
                        else if (i_q_data.is_space)      s_space = 1'b1;
                        else if (i_q_data.is_plus || i_q_data.is_minus) s_sign = 1'b1;
                        else if (lead_zero)              s_lzero = 1'b1;
                        else                             s_digit = 1'b1;
                    end
                    stus_pkg::PH_SIGN: begin
                        priority if (!i_q_data.readable) s_fin   = 1'b1;
                        else if (lead_zero)              s_lzero = 1'b1;
                        else                             s_digit = 1'b1;
                    end
                    stus_pkg::PH_ZERO: begin
                        priority if (!i_q_data.readable) s_fin   = 1'b1;
                        else if (i_q_data.is_x)          s_xmark = 1'b1;
                        else                             s_digit = 1'b1;
                    end
                    stus_pkg::PH_XMARK: begin
                        // Only a hex digit makes the x part of the number
                        if (i_q_data.readable && i_q_data.is_digit
                            && (i_q_data.digit < stus_pkg::DIGIT_BITS'(stus_pkg::BASE_HEX))) begin
                            s_digit = 1'b1;
                        end else begin
                            s_fin     = 1'b1;
                            s_fin_end = r_fb;
                        end
                    end
                    stus_pkg::PH_DIGITS: begin
                        if (!i_q_data.readable) begin
                            s_fin     = 1'b1;
                            s_fin_end = r_sd ? r_pos : '0;
                        end else begin
                            s_digit = 1'b1;
                        end
                    end
                    default: ;
                endcase
                // A byte that is no digit of the base ends the scan
                if (s_digit && d_bad) begin
                    s_fin     = 1'b1;
                    s_fin_end = e_sd ? d_pos : '0;
                end
            end
        end
    end

    // Pop unless a finishing byte meets a full result register
    assign slot_free = !r_out_valid || i_out_ready;
    assign o_q_ready = !s_fin || slot_free;
    assign go        = i_q_valid && o_q_ready;

    // Next state
    always_comb begin
        n_phase = r_phase;
        if (go) begin
            priority if (s_fin)  n_phase = stus_pkg::PH_IDLE;
            else if (s_space)    n_phase = stus_pkg::PH_WS;
            else if (s_sign)     n_phase = stus_pkg::PH_SIGN;
            else if (s_lzero)    n_phase = stus_pkg::PH_ZERO;
            else if (s_xmark)    n_phase = stus_pkg::PH_XMARK;
            else if (s_digit)    n_phase = stus_pkg::PH_DIGITS;
            else                 n_phase = r_phase;
        end
    end

    // Datapath updates and result
    always_comb begin
        n_base = r_base;
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_fb   = r_fb;
        n_sd   = r_sd;
        n_sm   = r_sm;
        n_ov   = r_ov;
        if (go) begin
            if (i_q_data.first) begin
                n_base = i_q_data.base;
                n_acc  = '0;
                n_pos  = '0;
                n_fb   = '0;
                n_sd   = 1'b0;
                n_sm   = 1'b0;
                n_ov   = 1'b0;
            end
            if (!s_fin) begin
                priority if (s_space) begin
                    n_pos = e_pos + OB'(1);
                end else if (s_sign) begin
                    n_sm  = i_q_data.is_minus;
                    n_pos = e_pos + OB'(1);
                end else if (s_lzero) begin
                    // Leading zero: octal in auto mode, maybe an 0x prefix
                    n_base = (e_base == '0) ? BB'(stus_pkg::BASE_OCT) : e_base;
                    n_sd   = 1'b1;
                    n_acc  = '0;
                    n_pos  = e_pos + OB'(1);
                    n_fb   = e_pos + OB'(1);
                end else if (s_digit) begin
                    n_base = d_base;
                    n_sd   = 1'b1;
                    if (d_ovf) begin
                        n_ov = 1'b1;
                    end else begin
                        n_acc = prod[VB-1:0];
                    end
                    n_pos = d_pos + OB'(1);
                end else begin
                    n_pos = r_pos;
                end
            end
        end
        res.value      = e_sd ? e_acc : '0;
        res.end_offset = s_fin_end;
        res.negative   = e_sd && e_sm;
        res.overflow   = e_sd && e_ov;
        res.converted  = e_sd;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= stus_pkg::PH_IDLE;
            r_base  <= '0;
            r_acc   <= '0;
            r_pos   <= '0;
            r_fb    <= '0;
            r_sd    <= 1'b0;
            r_sm    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_fb    <= n_fb;
            r_sd    <= n_sd;
            r_sm    <= n_sm;
            r_ov    <= n_ov;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && s_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && s_fin) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
